FILE: rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define WPM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication, disabled while reset is asserted
`define WPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

FILE: rtl/wpm_pkg.sv
// shared constants, types and control structs for the window peak and mean block
package wpm_pkg;

    localparam int WINDOW_SLOTS = 48;
    localparam int SLOT_W       = 6;
    localparam int DATA_W       = 16;
    localparam int IDX_W        = $clog2(WINDOW_SLOTS);
    localparam int CNT_W        = $clog2(WINDOW_SLOTS + 1);
    localparam int SUM_W        = DATA_W + IDX_W;
    localparam int DIV_CNT_W    = $clog2(DATA_W);

    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [DATA_W-1:0]    data_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [SUM_W-1:0]     sum_t;
    typedef logic [IDX_W-1:0]     rem_t;
    typedef logic [IDX_W:0]       trial_t;
    typedef logic [DIV_CNT_W-1:0] div_cnt_t;

    typedef struct packed {
        logic accept;
        logic sweep_read;
        logic div_load;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic div_last;
    } sts_t;

endpackage

FILE: rtl/wpm_if.sv
// request and result channel interfaces
interface wpm_in_if
    import wpm_pkg::*;
();
    logic  valid;
    logic  ready;
    slot_t slot;
    data_t sample_value;
    logic  window_full;

    modport source (output valid, output slot, output sample_value, output window_full,
                    input ready);
    modport sink   (input valid, input slot, input sample_value, input window_full,
                    output ready);
endinterface

interface wpm_out_if
    import wpm_pkg::*;
();
    logic  valid;
    logic  ready;
    data_t peak_value;
    data_t mean_value;

    modport source (output valid, output peak_value, output mean_value, input ready);
    modport sink   (input valid, input peak_value, input mean_value, output ready);
endinterface

FILE: rtl/wpm_ctrl.sv
// sequencer for store, ring sweep, division and result handoff
module wpm_ctrl
    import wpm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_TAIL,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.accept     = in_valid && in_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_read = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_TAIL;
                end
            end
            // last read word is folded into the sums here
            ST_TAIL:
            begin
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/wpm_datapath.sv
// sample ring memory, peak and sum accumulators, restoring divider, result register
module wpm_datapath
    import wpm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    output sts_t  sts,
    input  slot_t slot,
    input  data_t sample_value,
    input  logic  window_full,
    output data_t peak_value,
    output data_t mean_value
);

    data_t                   ring_mem [WINDOW_SLOTS];
    logic [WINDOW_SLOTS-1:0] written_reg;

    idx_t     rd_addr_reg;
    idx_t     rd_idx_reg;
    logic     rd_pend_reg;
    logic     rd_ok_reg;
    data_t    rd_data_reg;
    cnt_t     count_reg;
    cnt_t     count_next;
    data_t    peak_reg;
    sum_t     sum_reg;
    rem_t     rem_reg;
    data_t    quo_reg;
    div_cnt_t div_cnt_reg;
    data_t    peak_out_reg;
    data_t    mean_out_reg;

    logic     slot_ok;
    data_t    rd_value;
    trial_t   trial;
    logic     trial_ge;

    assign slot_ok  = (int'(slot) < WINDOW_SLOTS);
    assign rd_value = rd_ok_reg ? rd_data_reg : '0;
    assign trial    = {rem_reg, quo_reg[DATA_W-1]};
    assign trial_ge = (trial >= trial_t'(count_reg));

    assign sts.sweep_last = (rd_addr_reg == idx_t'(WINDOW_SLOTS - 1));
    assign sts.div_last   = (div_cnt_reg == div_cnt_t'(DATA_W - 1));

    assign peak_value = peak_out_reg;
    assign mean_value = mean_out_reg;

    // a full window or an out-of-range slot averages over the whole ring, else slots 0 to slot
    always_comb
    begin
        if (window_full || !slot_ok)
        begin
            count_next = cnt_t'(WINDOW_SLOTS);
        end
        else
        begin
            count_next = cnt_t'(slot) + cnt_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && slot_ok)
        begin
            ring_mem[idx_t'(slot)] <= sample_value;
        end
        rd_data_reg <= ring_mem[rd_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_addr_reg <= '0;
            rd_pend_reg <= 1'b0;
            rd_ok_reg   <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.accept && slot_ok)
            begin
                written_reg[idx_t'(slot)] <= 1'b1;
            end
            rd_pend_reg <= cmd.sweep_read;
            rd_ok_reg   <= written_reg[rd_addr_reg];
            if (cmd.accept)
            begin
                rd_addr_reg <= '0;
            end
            else if (cmd.sweep_read)
            begin
                rd_addr_reg <= rd_addr_reg + idx_t'(1);
            end
            if (cmd.div_load)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + div_cnt_t'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_addr_reg;
        if (cmd.accept)
        begin
            count_reg <= count_next;
            peak_reg  <= '0;
            sum_reg   <= '0;
        end
        else if (rd_pend_reg)
        begin
            if (rd_value > peak_reg)
            begin
                peak_reg <= rd_value;
            end
            if (cnt_t'(rd_idx_reg) < count_reg)
            begin
                sum_reg <= sum_reg + sum_t'(rd_value);
            end
        end
        // quotient fits in DATA_W bits, so the top sum bits start as the remainder
        if (cmd.div_load)
        begin
            rem_reg <= sum_reg[SUM_W-1:DATA_W];
            quo_reg <= sum_reg[DATA_W-1:0];
        end
        else if (cmd.div_step)
        begin
            if (trial_ge)
            begin
                rem_reg <= rem_t'(trial - trial_t'(count_reg));
            end
            else
            begin
                rem_reg <= trial[IDX_W-1:0];
            end
            quo_reg <= {quo_reg[DATA_W-2:0], trial_ge};
        end
        if (cmd.out_load)
        begin
            peak_out_reg <= peak_reg;
            mean_out_reg <= quo_reg;
        end
    end

endmodule

FILE: rtl/window_peak_and_mean_core.sv
// Window peak and mean core: each request stores a 16-bit sample in one of 48 ring slots
// (a slot of 48 or above leaves the ring unchanged), then sweeps the ring once to find the
// largest value and the sum of the averaged slots, and divides that sum by the slot count
// with a one-bit-per-cycle restoring divider. A request passes through these steps in order:
// the idle state in which it is taken, ring reads of all 48 slots through the single memory
// read port, a tail state that finishes the sums, a state that loads the divider, 16 divider
// steps, and a done state that loads the result register. If the previous result
// has not been taken when the division ends, loading the new one waits until it is. The
// result stays in its register until taken while the next request is already accepted and
// worked on. The ring reads as zero after reset through per-slot written flags, so no
// clearing pass is needed.
module window_peak_and_mean_core
    import wpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    wpm_in_if.sink      in_ch,
    wpm_out_if.source   out_ch
);

    cmd_t cmd;
    sts_t sts;

    wpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    wpm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .slot         (in_ch.slot),
        .sample_value (in_ch.sample_value),
        .window_full  (in_ch.window_full),
        .peak_value   (out_ch.peak_value),
        .mean_value   (out_ch.mean_value)
    );

endmodule

FILE: rtl/wpm_checker.sv
// port-level checker for the window peak and mean core, with its bind
`include "assert_macros.svh"

module wpm_checker
    import wpm_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input logic  out_valid,
    input logic  out_ready,
    input data_t peak_value,
    input data_t mean_value
);

    logic in_fire;
    logic out_stall;

    assign in_fire   = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;

    // a held result does not change under backpressure
    `WPM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, $stable(peak_value) && $stable(mean_value))
    // the sweep keeps the request side closed right after an accept
    `WPM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ready)
    // no result can be produced in the cycle after an accept
    `WPM_ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_fire, !$rose(out_valid))
    // a mean never exceeds the largest stored value
    `WPM_ASSERT_IMPLY(a_mean_le_peak, clk, rst_n, out_valid, mean_value <= peak_value)

endmodule

bind window_peak_and_mean_core wpm_checker u_wpm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .peak_value (out_ch.peak_value),
    .mean_value (out_ch.mean_value)
);

FILE: tb/window_stats_checker.sv
// checker for the window peak and mean core: predicts each result and compares it
`timescale 1ns / 1ps

module window_stats_checker
    import wpm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    wpm_in_if    in_ch,
    wpm_out_if   out_ch,
    output int   mismatches,
    output int   results_due,
    output int   results_seen
);

    typedef struct packed {
        data_t peak;
        data_t mean;
    } window_stats_t;

    data_t         held_samples [WINDOW_SLOTS];
    window_stats_t stats_due [$];
    window_stats_t got;
    window_stats_t want;

    // store the sample, then take the peak over the whole ring and the mean over the span
    function automatic window_stats_t store_and_summarize(input slot_t s, input data_t v,
                                                          input logic f);
        window_stats_t r;
        int unsigned   total;
        int unsigned   span;
        r.peak = '0;
        total  = 0;
        if (s < WINDOW_SLOTS)
            held_samples[s] = v;
        // a full window or a slot past the ring counts as the whole ring for the mean
        if (f || s >= WINDOW_SLOTS)
            span = WINDOW_SLOTS;
        else
            span = s + 1;
        for (int k = 0; k < WINDOW_SLOTS; k++)
        begin
            if (held_samples[k] > r.peak)
                r.peak = held_samples[k];
            if (k < span)
                total += held_samples[k];
        end
        r.mean = data_t'(total / span);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (held_samples[k])
                held_samples[k] = '0;
            stats_due.delete();
            mismatches   = 0;
            results_due  = 0;
            results_seen = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                stats_due.push_back(store_and_summarize(in_ch.slot, in_ch.sample_value,
                                                        in_ch.window_full));
            if (out_ch.valid && out_ch.ready)
            begin
                got.peak = out_ch.peak_value;
                got.mean = out_ch.mean_value;
                if (stats_due.size() == 0)
                begin
                    $error("result with no request outstanding: peak_value %h mean_value %h",
                           got.peak, got.mean);
                    mismatches++;
                end
                else
                begin
                    want = stats_due.pop_front();
                    results_seen++;
                    if (got.peak !== want.peak)
                    begin
                        $error("peak_value mismatch: expected %h, got %h", want.peak, got.peak);
                        mismatches++;
                    end
                    if (got.mean !== want.mean)
                    begin
                        $error("mean_value mismatch: expected %h, got %h", want.mean, got.mean);
                        mismatches++;
                    end
                end
            end
            results_due = stats_due.size();
        end
    end

endmodule

FILE: tb/tb_window_peak_and_mean_core.sv
// top of the window peak and mean testbench: clock, reset, request traffic and verdict
`timescale 1ns / 1ps

module tb_window_peak_and_mean_core;
    import wpm_pkg::*;

    localparam int RANDOM_ITEMS   = 500;
    localparam int CALM_TAIL      = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 100;

    logic clk = 1'b0;
    logic rst_n;

    wpm_in_if  in_ch ();
    wpm_out_if out_ch ();

    int mismatches;
    int results_due;
    int results_seen;

    int    sent;
    int    past_ring;
    int    full_flags;
    int    stall_cycles;
    int    run_len;
    int    target;
    bit    idle_on;
    bit    wrapped;
    bit    drained_mid;
    slot_t run_ptr;

    window_peak_and_mean_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    window_stats_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .mismatches   (mismatches),
        .results_due  (results_due),
        .results_seen (results_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: random bursts of back-pressure while idling is on
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge clk);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic data_t pick_sample();
        data_t v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            2:       v = data_t'($urandom_range(0, 15));
            3:       v = data_t'($urandom_range(16'hFF00, 16'hFFFF));
            default: v = data_t'($urandom);
        endcase
        return v;
    endfunction

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_req(input slot_t s, input data_t v, input logic f);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.slot         <= s;
        in_ch.sample_value <= v;
        in_ch.window_full  <= f;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sent++;
        if (s >= WINDOW_SLOTS)
            past_ring++;
        if (f)
            full_flags++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.slot         = '0;
        in_ch.sample_value = '0;
        in_ch.window_full  = 1'b0;
        idle_on            = 1'b1;
        sent               = 0;
        past_ring          = 0;
        full_flags         = 0;
        drained_mid        = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty ring, extremes, slots past the ring, both flag values
        send_req(6'd0, 16'h0000, 1'b0);
        send_req(6'd63, 16'h1234, 1'b0);
        send_req(6'd0, 16'hFFFF, 1'b0);
        send_req(6'd1, 16'hFFFF, 1'b0);
        send_req(6'd47, 16'hFFFF, 1'b0);
        send_req(6'd47, 16'h0000, 1'b1);
        send_req(6'd48, 16'hAAAA, 1'b0);
        send_req(6'd48, 16'h5555, 1'b1);
        send_req(6'd5, 16'h0001, 1'b1);
        send_req(6'd32, 16'h8000, 1'b0);
        send_req(6'd16, 16'h7FFF, 1'b1);
        send_req(6'd0, 16'h0000, 1'b0);
        send_req(6'd1, 16'h0000, 1'b0);
        send_req(6'd62, 16'hFFFF, 1'b1);
        send_req(6'd42, 16'h5555, 1'b0);
        send_req(6'd21, 16'hAAAA, 1'b1);
        drain_results();

        // random: mostly in-order ring fills, some restarts and some scattered requests
        target  = sent + RANDOM_ITEMS;
        run_ptr = '0;
        wrapped = 1'b0;
        while (sent < target)
        begin
            idle_on = (target - sent > CALM_TAIL) && ($urandom_range(0, 3) != 0);
            if (!drained_mid && target - sent < RANDOM_ITEMS / 2)
            begin
                drain_results();
                drained_mid = 1'b1;
            end
            case ($urandom_range(0, 9))
                7:
                begin
                    run_ptr = '0;
                    wrapped = 1'b0;
                end
                8, 9:
                begin
                    run_len = $urandom_range(1, 8);
                    repeat (run_len)
                        send_req(slot_t'($urandom_range(0, 63)), pick_sample(),
                                 logic'($urandom_range(0, 1)));
                end
                default:
                begin
                    run_len = $urandom_range(1, 60);
                    repeat (run_len)
                    begin
                        send_req(run_ptr, pick_sample(), wrapped);
                        if (run_ptr == WINDOW_SLOTS - 1)
                        begin
                            run_ptr = '0;
                            wrapped = 1'b1;
                        end
                        else
                            run_ptr = run_ptr + 1'b1;
                    end
                end
            endcase
        end
        idle_on = 1'b0;
        in_ch.valid <= 1'b0;

        while (results_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("covered %0d requests: %0d with a slot past the ring, %0d with the window full",
                 sent, past_ring, full_flags);
        $display("compared %0d results, %0d field mismatches, %0d results missing",
                 results_seen, mismatches, results_due);
        if (mismatches == 0 && results_due == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/wpm_pkg.sv
rtl/wpm_if.sv
rtl/wpm_ctrl.sv
rtl/wpm_datapath.sv
rtl/window_peak_and_mean_core.sv
rtl/wpm_checker.sv
tb/window_stats_checker.sv
tb/tb_window_peak_and_mean_core.sv
